// File: rtl/cfl_pkg.sv
// Shared types and constants for the correlation fault locator.
package cfl_pkg;

  localparam int MaxSamples = 512;

  localparam logic [9:0]  CorrLengthReset     = 10'd320;
  localparam logic [8:0]  MaskHalfwidthReset  = 9'd60;
  localparam logic [23:0] DistanceScaleReset  = 24'd207530;
  localparam logic [6:0]  SignalThresholdReset = 7'd5;
  localparam logic [8:0]  PresenceStartReset  = 9'd130;

  localparam logic [7:0]  Mid     = 8'd128;
  localparam logic [25:0] DistMax = 26'h3FFFFFF;

  typedef enum logic [2:0] {
    REG_CORR_LENGTH      = 3'd0,
    REG_MASK_HALFWIDTH   = 3'd1,
    REG_DISTANCE_SCALE   = 3'd2,
    REG_SIGNAL_THRESHOLD = 3'd3,
    REG_PRESENCE_START   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [7:0] rx_sample;
    logic [7:0] ref_sample;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  first_peak_index;
    logic [9:0]  second_peak_index;
    logic [9:0]  lag_gap;
    logic [25:0] distance;
    logic        polarity;
    logic        signal_present;
  } out_item_t;

  // job handed from the loader to the correlation engine
  typedef struct packed {
    logic [12:0] count;
    logic        present;
  } job_t;

endpackage

// File: rtl/cfl_front.sv
// Capture loader: stores samples, tracks presence, queues a job on the last item.
module cfl_front #(
  parameter int MAX_SAMPLES = cfl_pkg::MaxSamples,
  localparam int AW = $clog2(MAX_SAMPLES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cfl_pkg::in_item_t item,
  input  logic [8:0]        presence_start,
  input  logic [6:0]        signal_threshold,
  input  logic              queue_full,
  output logic              busy,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [15:0]       wr_data,
  output logic              job_push,
  output cfl_pkg::job_t     job
);

  logic [AW:0] sample_count;
  logic        presence_flag;
  logic        accept;
  logic        room;
  logic [7:0]  dev;
  logic        hit;

  assign busy   = queue_full;
  assign accept = start && !busy;
  assign room   = sample_count < (AW+1)'(MAX_SAMPLES);
  assign dev    = (item.rx_sample >= cfl_pkg::Mid) ? item.rx_sample - cfl_pkg::Mid
                                                   : cfl_pkg::Mid - item.rx_sample;
  assign hit    = room && (13'(presence_start) <= 13'(sample_count))
                  && (dev > {1'b0, signal_threshold});

  assign wr_en   = accept && room;
  assign wr_addr = sample_count[AW-1:0];
  assign wr_data = {item.rx_sample, item.ref_sample};
  assign job_push = accept && item.last;
  assign job.count   = 13'(sample_count + (AW+1)'(room));
  assign job.present = presence_flag || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      presence_flag <= 1'b0;
    end else if (accept) begin
      if (item.last) begin
        sample_count  <= '0;
        presence_flag <= 1'b0;
      end else begin
        if (room) sample_count <= sample_count + 1'b1;
        if (hit) presence_flag <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/cfl_back.sv
// Correlation engine: MAC over stored samples, two peak scans, distance multiply.
module cfl_back #(
  parameter int MAX_SAMPLES = cfl_pkg::MaxSamples,
  localparam int AW = $clog2(MAX_SAMPLES),
  localparam int CW = AW + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  cfl_pkg::job_t     job,
  output logic              job_pop,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [15:0]       wr_data,
  input  logic [9:0]        corr_length,
  input  logic [8:0]        mask_halfwidth,
  input  logic [23:0]       distance_scale,
  output logic              active,
  output logic              done,
  output cfl_pkg::out_item_t result
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_STORE, S_SCAN1, S_SCAN2, S_POL, S_MUL, S_OUT
  } state_t;

  state_t state;

  logic [7:0]  rx_mem   [MAX_SAMPLES];
  logic [7:0]  ref_mem  [MAX_SAMPLES];
  logic [24:0] corr_mem [2*MAX_SAMPLES-1];

  logic [CW-1:0] n, cnt, len;
  logic          present;
  logic [CW-1:0] lagi;     // correlation index being built
  logic [CW-1:0] i;        // rx position
  logic signed [CW+1:0] j; // ref position
  logic          rd_ok, ok_q, pipe_v;
  logic [7:0]    rx_q, ref_q;
  logic signed [8:0]  a, b;
  logic signed [16:0] p;
  logic signed [24:0] acc, acc_sum;
  logic [CW-1:0] scan_k, rd_idx, rd_addr;
  logic          rd_v;
  logic signed [24:0] rd_data;
  logic [24:0]   cur_mag, best;
  logic          masked, take;
  logic [CW-1:0] first, second;
  logic [9:0]    gap;
  logic [33:0]   prod;
  logic          pol;

  assign active = (state != S_IDLE);
  assign len    = CW'({n, 1'b0} - 1'b1);

  // lag d = lagi - n + 1; rx index i, ref index j = i + d
  assign j = $signed({2'b00, i}) + $signed({2'b00, lagi}) - $signed({2'b00, n})
             + $signed((CW+2)'(1));

  // positions past the loaded count read as mid scale, i.e. contribute nothing
  assign rd_ok = !j[CW+1] && (j < $signed({2'b00, n})) && (i < cnt) &&
                 (j < $signed({2'b00, cnt}));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rx_mem[wr_addr]  <= wr_data[15:8];
      ref_mem[wr_addr] <= wr_data[7:0];
    end
    rx_q  <= rx_mem[i[AW-1:0]];
    ref_q <= ref_mem[j[AW-1:0]];
  end

  assign a = $signed({1'b0, rx_q}) - 9'sd128;
  assign b = $signed({1'b0, ref_q}) - 9'sd128;
  assign p = a * b;
  assign acc_sum = (pipe_v && ok_q) ? acc + 25'(p) : acc;

  assign rd_addr = (state == S_POL) ? second : scan_k;

  always_ff @(posedge clk) begin
    if (state == S_STORE) corr_mem[lagi] <= acc_sum;
    rd_data <= corr_mem[rd_addr];
  end

  assign cur_mag = rd_data[24] ? 25'(-rd_data) : 25'(rd_data);
  // window first-H .. first+H-1; ends past the valid range fall away by themselves
  assign masked  = (16'(rd_idx) + 16'(mask_halfwidth) >= 16'(first)) &&
                   (16'(rd_idx) < 16'(first) + 16'(mask_halfwidth));
  assign take    = rd_v && (state == S_SCAN1 || !masked) && (cur_mag > best);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      job_pop <= 1'b0;
    end else begin
      done    <= 1'b0;
      job_pop <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid && !job_pop) begin
            job_pop <= 1'b1;
            n <= (corr_length == 10'd0) ? CW'(1) :
                 (13'(corr_length) > 13'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) :
                 CW'(corr_length);
            cnt     <= CW'(job.count);
            present <= job.present;
            lagi    <= '0;
            i       <= '0;
            acc     <= '0;
            pipe_v  <= 1'b0;
            state   <= S_MAC;
          end
        end
        S_MAC: begin
          ok_q   <= rd_ok;
          pipe_v <= 1'b1;
          acc    <= acc_sum;
          if (i == n - 1'b1) state <= S_STORE;
          else i <= i + 1'b1;
        end
        S_STORE: begin
          // last product folds in as the lag is written
          acc    <= '0;
          i      <= '0;
          pipe_v <= 1'b0;
          if (lagi == len - 1'b1) begin
            scan_k <= '0;
            rd_v   <= 1'b0;
            best   <= '0;
            first  <= '0;
            state  <= S_SCAN1;
          end else begin
            lagi  <= lagi + 1'b1;
            state <= S_MAC;
          end
        end
        S_SCAN1, S_SCAN2: begin
          if (rd_v && rd_idx == len - 1'b1) begin
            scan_k <= '0;
            rd_v   <= 1'b0;
            best   <= '0;
            if (state == S_SCAN1) begin
              if (take) first <= rd_idx;
              second <= '0;
              state  <= S_SCAN2;
            end else begin
              if (take) second <= rd_idx;
              state <= S_POL;
            end
          end else begin
            rd_v   <= (scan_k < len);
            rd_idx <= scan_k;
            if (scan_k < len) scan_k <= scan_k + 1'b1;
            if (take) begin
              best <= cur_mag;
              if (state == S_SCAN1) first <= rd_idx;
              else second <= rd_idx;
            end
          end
        end
        S_POL: begin
          gap   <= 10'((second > first) ? second - first : first - second);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 34'(gap) * 34'(distance_scale);
          pol   <= !rd_data[24];
          state <= S_OUT;
        end
        S_OUT: begin
          result.first_peak_index  <= 10'(first);
          result.second_peak_index <= 10'(second);
          result.lag_gap  <= gap;
          result.distance <= (prod[33:8] > cfl_pkg::DistMax) ? cfl_pkg::DistMax
                                                              : prod[33:8];
          result.polarity <= pol;
          result.signal_present <= present;
          done  <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/correlation_fault_locator.sv
// Top level of the correlation fault locator.
// Items (rx byte, ref byte, last) enter on start when busy is low, one per
// cycle while the correlation engine is idle. The last item closes a capture
// and queues a job; busy then stays high until the result is out, since the
// engine reads the same sample memories the loader writes.
// After the hand-off the engine computes the full cross-correlation, 2N-1
// lags for N = corr_length, with one multiply-accumulate unit, then runs
// two peak scans, the polarity step and the distance multiply.
// A result appears on result with done high for exactly one cycle; the
// receiver cannot stall it. Configuration writes land via cfg_valid/cfg_ready,
// always ready; write only while no capture is loading or in the engine.
// Reset clears the sample count, presence flag, queue and engine state;
// sample memories hold undefined data until loaded.
module correlation_fault_locator #(
  parameter int MAX_SAMPLES = cfl_pkg::MaxSamples
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cfl_pkg::in_item_t  item,
  output logic               busy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               done,
  output cfl_pkg::out_item_t result
);

  localparam int AW = $clog2(MAX_SAMPLES);

  logic [9:0]  corr_length;
  logic [8:0]  mask_halfwidth;
  logic [23:0] distance_scale;
  logic [6:0]  signal_threshold;
  logic [8:0]  presence_start;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corr_length      <= cfl_pkg::CorrLengthReset;
      mask_halfwidth   <= cfl_pkg::MaskHalfwidthReset;
      distance_scale   <= cfl_pkg::DistanceScaleReset;
      signal_threshold <= cfl_pkg::SignalThresholdReset;
      presence_start   <= cfl_pkg::PresenceStartReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfl_pkg::REG_CORR_LENGTH:      corr_length      <= cfg_data[9:0];
        cfl_pkg::REG_MASK_HALFWIDTH:   mask_halfwidth   <= cfg_data[8:0];
        cfl_pkg::REG_DISTANCE_SCALE:   distance_scale   <= cfg_data;
        cfl_pkg::REG_SIGNAL_THRESHOLD: signal_threshold <= cfg_data[6:0];
        cfl_pkg::REG_PRESENCE_START:   presence_start   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // one-entry job queue between loader and engine
  logic          q_valid, job_push, job_pop;
  cfl_pkg::job_t q_job, job;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          engine_busy;
  logic          hold;

  // loader waits while a job is queued or the engine still reads the memories
  assign hold = q_valid || engine_busy;

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (job_push) q_valid <= 1'b1;
    else if (job_pop) q_valid <= 1'b0;
    if (job_push) q_job <= job;
  end

  cfl_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst, .start, .item, .presence_start, .signal_threshold,
    .queue_full(hold), .busy, .wr_en, .wr_addr, .wr_data, .job_push, .job
  );

  cfl_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk, .rst, .job_valid(q_valid), .job(q_job), .job_pop,
    .wr_en, .wr_addr, .wr_data, .corr_length, .mask_halfwidth, .distance_scale,
    .active(engine_busy), .done, .result
  );

endmodule

// File: dv/correlation_fault_locator_tb.sv
// Testbench for correlation_fault_locator: directed and random captures checked against a local peak predictor.
module correlation_fault_locator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 2 * cfl_pkg::MaxSamples - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cfl_pkg::in_item_t item = '0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic done;
  cfl_pkg::out_item_t result;

  correlation_fault_locator dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  always #6 clk = ~clk;

  // shadow registers and capture state
  logic [9:0] sh_len = cfl_pkg::CorrLengthReset;
  logic [8:0] sh_halfw = cfl_pkg::MaskHalfwidthReset;
  logic [23:0] sh_scale = cfl_pkg::DistanceScaleReset;
  logic [6:0] sh_thresh = cfl_pkg::SignalThresholdReset;
  logic [8:0] sh_pstart = cfl_pkg::PresenceStartReset;
  logic [7:0] rx_mem [cfl_pkg::MaxSamples];
  logic [7:0] ref_mem [cfl_pkg::MaxSamples];
  int loaded = 0;
  bit seen_signal = 0;

  cfl_pkg::in_item_t pending_items[$];
  cfl_pkg::out_item_t peak_reports[$];
  int queued = 0;
  int taken = 0;
  int idle_pct = 20;
  bit failed = 0;

  function automatic int centred(logic [7:0] mem [cfl_pkg::MaxSamples], int pos);
    if (pos < 0 || pos >= loaded) return 0;
    return int'(mem[pos]) - 128;
  endfunction

  // load one sample; on the last one compute the peak report
  function automatic bit locate_step(cfl_pkg::in_item_t it, output cfl_pkg::out_item_t rep);
    int corr [Depth];
    int mag [Depth];
    int n, len, acc, j, first, second, best, lo, hi, gap, dev;
    longint dist_v;
    rep = '0;
    if (loaded < cfl_pkg::MaxSamples) begin
      rx_mem[loaded] = it.rx_sample;
      ref_mem[loaded] = it.ref_sample;
      dev = int'(it.rx_sample) - 128;
      if (dev < 0) dev = -dev;
      if (loaded >= int'(sh_pstart) && dev > int'(sh_thresh)) seen_signal = 1;
      loaded++;
    end
    if (!it.last) return 0;
    n = int'(sh_len);
    if (n < 1) n = 1;
    if (n > cfl_pkg::MaxSamples) n = cfl_pkg::MaxSamples;
    len = 2 * n - 1;
    for (int d = -n + 1; d < n; d++) begin
      acc = 0;
      for (int i = 0; i < n; i++) begin
        j = i + d;
        if (j >= 0 && j < n) acc += centred(rx_mem, i) * centred(ref_mem, j);
      end
      corr[d + n - 1] = acc;
      mag[d + n - 1] = acc < 0 ? -acc : acc;
    end
    first = 0;
    best = mag[0];
    for (int k = 0; k < len; k++) if (mag[k] > best) begin best = mag[k]; first = k; end
    lo = first - int'(sh_halfw);
    hi = first + int'(sh_halfw);
    if (lo < 0) lo = 0;
    if (hi > len) hi = len;
    for (int k = lo; k < hi; k++) mag[k] = 0;
    second = 0;
    best = mag[0];
    for (int k = 0; k < len; k++) if (mag[k] > best) begin best = mag[k]; second = k; end
    gap = second > first ? second - first : first - second;
    dist_v = (longint'(gap) * longint'(sh_scale)) >>> 8;
    if (dist_v > longint'(cfl_pkg::DistMax)) dist_v = longint'(cfl_pkg::DistMax);
    rep.first_peak_index = first[9:0];
    rep.second_peak_index = second[9:0];
    rep.lag_gap = gap[9:0];
    rep.distance = dist_v[25:0];
    rep.polarity = corr[second] < 0 ? 1'b0 : 1'b1;
    rep.signal_present = seen_signal;
    loaded = 0;
    seen_signal = 0;
    return 1;
  endfunction

  // driver and acceptance tracking
  always @(posedge clk) begin
    cfl_pkg::out_item_t rep;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken++;
        if (locate_step(item, rep)) peak_reports.push_back(rep);
      end
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          item <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      failed = 1;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    cfl_pkg::out_item_t exp_r;
    if (!rst && done) begin
      if (peak_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, result);
        failed = 1;
      end else begin
        exp_r = peak_reports.pop_front();
        check_field("first_peak_index", exp_r.first_peak_index, result.first_peak_index);
        check_field("second_peak_index", exp_r.second_peak_index, result.second_peak_index);
        check_field("lag_gap", exp_r.lag_gap, result.lag_gap);
        check_field("distance", exp_r.distance, result.distance);
        check_field("polarity", exp_r.polarity, result.polarity);
        check_field("signal_present", exp_r.signal_present, result.signal_present);
      end
    end
  end

  task automatic write_reg(cfl_pkg::reg_index_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cfl_pkg::REG_CORR_LENGTH: sh_len = val[9:0];
      cfl_pkg::REG_MASK_HALFWIDTH: sh_halfw = val[8:0];
      cfl_pkg::REG_DISTANCE_SCALE: sh_scale = val;
      cfl_pkg::REG_SIGNAL_THRESHOLD: sh_thresh = val[6:0];
      cfl_pkg::REG_PRESENCE_START: sh_pstart = val[8:0];
      default: ;
    endcase
  endtask

  task automatic configure(int len, int halfw, int scale, int thresh, int pstart);
    write_reg(cfl_pkg::REG_CORR_LENGTH, 24'(len));
    write_reg(cfl_pkg::REG_MASK_HALFWIDTH, 24'(halfw));
    write_reg(cfl_pkg::REG_DISTANCE_SCALE, 24'(scale));
    write_reg(cfl_pkg::REG_SIGNAL_THRESHOLD, 24'(thresh));
    write_reg(cfl_pkg::REG_PRESENCE_START, 24'(pstart));
  endtask

  // wait until every item is taken and every report is out, then let the engine settle
  task automatic drain();
    while (taken != queued || peak_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] clip8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // mode 0: random bytes, 1: echoes of the reference, 2: near mid scale, 3: flat
  task automatic add_capture(int nsamp, int mode);
    cfl_pkg::in_item_t it;
    logic [7:0] refs [$];
    int a, b;
    a = $urandom_range(5);
    b = $urandom_range(12, 6);
    for (int i = 0; i < nsamp; i++) refs.push_back(8'($urandom_range(255)));
    for (int i = 0; i < nsamp; i++) begin
      it.ref_sample = refs[i];
      case (mode)
        0: it.rx_sample = 8'($urandom_range(255));
        1: it.rx_sample = clip8(128 + (i >= a ? (int'(refs[i - a]) - 128) / 2 : 0)
                                - (i >= b ? (int'(refs[i - b]) - 128) / 3 : 0));
        2: it.rx_sample = 8'd120 + 8'($urandom_range(16));
        default: it.rx_sample = 8'd128;
      endcase
      if (mode == 3) it.ref_sample = 8'd128;
      it.last = (i == nsamp - 1);
      pending_items.push_back(it);
      queued++;
    end
  endtask

  initial begin
    int nsamp;
    cfl_pkg::in_item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, flat capture, single sample, ties
    configure(8, 2, 24'hFFFFFF, 0, 0);
    for (int i = 0; i < 8; i++) begin
      it.rx_sample = i[0] ? 8'd255 : 8'd0;
      it.ref_sample = i[1] ? 8'd0 : 8'd255;
      it.last = (i == 7);
      pending_items.push_back(it);
      queued++;
    end
    add_capture(1, 0);
    add_capture(6, 3);
    drain();
    configure(0, 0, 0, 127, 511);
    add_capture(1, 0);
    add_capture(3, 0);
    drain();
    configure(12, 511, 1, 4, 3);
    add_capture(5, 2);
    add_capture(12, 1);
    drain();
    // capture overflow: samples past the store size are dropped
    configure(8, 3, 12345, 10, 500);
    add_capture(520, 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      idle_pct = p < 4 ? 20 : (p < 8 ? 50 : 0);
      configure($urandom_range(24, 1), $urandom_range(10), $urandom_range(24'hFFFFFF),
                $urandom_range(127), $urandom_range(20));
      while (queued < 530 + 52 * (p + 1)) begin
        nsamp = $urandom_range(24, 1);
        add_capture(nsamp, $urandom_range(9) < 5 ? 1 : $urandom_range(2));
      end
      drain();
    end

    // largest length, clamped to the store size
    idle_pct = 10;
    configure(1023, 40, 207530, 5, 0);
    add_capture(40, 1);
    drain();

    if (!failed) begin
      $display("correlation_fault_locator verification clean");
    end else begin
      $display("correlation_fault_locator verification failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("correlation_fault_locator verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/cfl_pkg.sv
rtl/cfl_front.sv
rtl/cfl_back.sv
rtl/correlation_fault_locator.sv
dv/correlation_fault_locator_tb.sv
